[sv/interpolating_variable_delay_line_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the interpolating variable delay line
// Concurrent checks clocked on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTERPOLATING_VARIABLE_DELAY_LINE_TOP_ASSERT_SVH
`define INTERPOLATING_VARIABLE_DELAY_LINE_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define IVDL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define IVDL_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

[sv/ivdl_pkg.sv]
// ----------------------------------------------------------------------------
// ivdl_pkg
// Widths, constants, shared types and the circular address helper.
// ----------------------------------------------------------------------------
package ivdl_pkg;

    localparam int MAX_DEPTH = 8192;
    localparam int SAMPLE_W  = 24;
    localparam int FRAC_W    = 8;
    localparam int INT_W     = 16;
    localparam int DELAY_W   = INT_W + FRAC_W;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int CFG_W     = 14;
    localparam int CMP_W     = (LEN_W + FRAC_W > DELAY_W) ? LEN_W + FRAC_W : DELAY_W;
    localparam int PROD_W    = FRAC_W + 1 + SAMPLE_W + 1;
    localparam int LEN_MIN   = 2;

    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(4800);

    // Register index, taken from the word address of the configuration port.
    localparam logic REG_BUFFER_LENGTH = 1'b0;

    typedef struct packed {
        logic                       valid;
        logic [ADDR_W-1:0]          wr_addr;
        logic [ADDR_W-1:0]          rd_addr1;
        logic [ADDR_W-1:0]          rd_addr2;
        logic signed [SAMPLE_W-1:0] sample;
        logic [FRAC_W-1:0]          frac;
    } ivdl_req_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
        logic [FRAC_W-1:0]          frac;
    } ivdl_rd_t;

    // Step back by back slots in a ring of len slots; pos < len, back <= len.
    function automatic logic [ADDR_W-1:0] wrap_back(input logic [ADDR_W-1:0] pos,
                                                    input logic [LEN_W-1:0]  back,
                                                    input logic [LEN_W-1:0]  len);
        logic [LEN_W-1:0] p;
        p = {1'b0, pos};
        if (p >= back)
        begin
            return ADDR_W'(p - back);
        end
        return ADDR_W'(p + len - back);
    endfunction

endpackage

[sv/ivdl_addr_gen.sv]
// ----------------------------------------------------------------------------
// ivdl_addr_gen
// Clamps the delay, forms both read addresses and keeps the write pointer.
// ----------------------------------------------------------------------------
module ivdl_addr_gen
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic signed [ivdl_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [ivdl_pkg::DELAY_W-1:0]        delay_samples,
    input  logic [ivdl_pkg::LEN_W-1:0]          len,
    output ivdl_pkg::ivdl_req_t                 req
);
    import ivdl_pkg::*;

    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic [ADDR_W-1:0] wp_eff;
    logic [LEN_W-1:0]  wp_inc;
    logic [ADDR_W-1:0] tap;
    logic [LEN_W-1:0]  tap1;
    logic [FRAC_W-1:0] frac;
    logic [CMP_W-1:0]  delay_ext;
    logic [CMP_W-1:0]  len_fx;
    ivdl_req_t         req_reg;
    ivdl_req_t         req_next;

    always_comb
    begin
        // A pointer left beyond a newly shortened ring restarts at slot zero.
        wp_eff    = ({1'b0, wp_reg} >= len) ? '0 : wp_reg;
        delay_ext = CMP_W'(delay_samples);
        len_fx    = CMP_W'({len, {FRAC_W{1'b0}}});

        if (delay_ext >= len_fx)
        begin
            tap  = ADDR_W'(len - 1'b1);
            frac = '0;
        end
        else if (delay_samples[DELAY_W-1:FRAC_W] == '0)
        begin
            tap  = ADDR_W'(1);
            frac = '0;
        end
        else
        begin
            tap  = delay_samples[FRAC_W +: ADDR_W];
            frac = delay_samples[FRAC_W-1:0];
        end
        tap1 = {1'b0, tap} + 1'b1;

        wp_inc  = {1'b0, wp_eff} + 1'b1;
        wp_next = (wp_inc == len) ? '0 : ADDR_W'(wp_inc);

        req_next.valid    = in_valid;
        req_next.wr_addr  = wp_eff;
        req_next.rd_addr1 = wrap_back(wp_eff, {1'b0, tap}, len);
        req_next.rd_addr2 = wrap_back(wp_eff, tap1, len);
        req_next.sample   = sample_in;
        req_next.frac     = frac;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            req_reg <= '0;
        end
        else if (adv)
        begin
            req_reg <= req_next;
            if (in_valid)
            begin
                wp_reg <= wp_next;
            end
        end
    end

    assign req = req_reg;

endmodule

[sv/ivdl_store.sv]
// ----------------------------------------------------------------------------
// ivdl_store
// Sample memory with two registered read ports, one write port and a fill count.
// ----------------------------------------------------------------------------
module ivdl_store
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  ivdl_pkg::ivdl_req_t req,
    output ivdl_pkg::ivdl_rd_t  rd
);
    import ivdl_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [MAX_DEPTH];
    logic signed [SAMPLE_W-1:0] q1_reg;
    logic signed [SAMPLE_W-1:0] q2_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       valid_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [LEN_W-1:0]           filled_reg;
    logic [LEN_W-1:0]           filled_next;

    // Writes walk upwards from slot zero, so the written slots always form
    // a prefix of the memory; anything at or above the count still reads zero.
    always_comb
    begin
        filled_next = filled_reg;
        if (adv && req.valid && ({1'b0, req.wr_addr} == filled_reg))
        begin
            filled_next = filled_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_reg   <= mem[req.rd_addr1];
            q2_reg   <= mem[req.rd_addr2];
            v1_reg   <= {1'b0, req.rd_addr1} < filled_reg;
            v2_reg   <= {1'b0, req.rd_addr2} < filled_reg;
            frac_reg <= req.frac;
            if (req.valid)
            begin
                mem[req.wr_addr] <= req.sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
            if (adv)
            begin
                valid_reg <= req.valid;
            end
        end
    end

    assign rd.valid = valid_reg;
    assign rd.y1    = v1_reg ? q1_reg : '0;
    assign rd.y2    = v2_reg ? q2_reg : '0;
    assign rd.frac  = frac_reg;

`include "interpolating_variable_delay_line_top_assert.svh"

    `IVDL_ASSERT(a_fill_bound, filled_reg <= LEN_W'(MAX_DEPTH), "fill count beyond depth")
    `IVDL_ASSERT(a_write_prefix, (adv && req.valid) |-> ({1'b0, req.wr_addr} <= filled_reg), "write skips past the filled prefix")
    `IVDL_ASSERT_NEXT(a_fill_grows, adv && req.valid && ({1'b0, req.wr_addr} == filled_reg), filled_reg == $past(filled_reg) + 1'b1, "fill count did not grow")

endmodule

[sv/ivdl_interp.sv]
// ----------------------------------------------------------------------------
// ivdl_interp
// Linear interpolation between the two stored samples, and the output register.
// ----------------------------------------------------------------------------
module ivdl_interp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  ivdl_pkg::ivdl_rd_t                  rd,
    output logic                                out_valid,
    output logic signed [ivdl_pkg::SAMPLE_W-1:0] out_data
);
    import ivdl_pkg::*;

    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] y1_reg;
    logic                       p_valid_reg;
    logic signed [PROD_W-1:0]   shifted;
    logic signed [SAMPLE_W:0]   sum;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    always_comb
    begin
        diff    = $signed({rd.y2[SAMPLE_W-1], rd.y2}) - $signed({rd.y1[SAMPLE_W-1], rd.y1});
        prod    = $signed({1'b0, rd.frac}) * diff;
        // Arithmetic shift floors the product, as the format requires.
        shifted = prod_reg >>> FRAC_W;
        sum     = $signed({y1_reg[SAMPLE_W-1], y1_reg}) + $signed(shifted[SAMPLE_W:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg     <= prod;
            y1_reg       <= rd.y1;
            out_data_reg <= sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg   <= rd.valid;
            out_valid_reg <= p_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[sv/interpolating_variable_delay_line_top.sv]
// ----------------------------------------------------------------------------
// interpolating_variable_delay_line_top
// Fractional delay line with linear interpolation over a circular sample store.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word
// s_axis    in         sample_in [23:0], delay_samples [47:24] (16.8 unsigned)
// m_axis    out        sample_out [23:0]
// apb       in/out     buffer_length at byte address 0, bits [13:0]
//
// One word is taken every cycle unless the output word is left waiting;
// the four-stage pipeline runs address generation, memory read and write,
// multiply and add. The rate is set by the sample memory: two read ports
// and one write port serve each word together.
// Reset is asynchronous and active low. The memory needs no clearing pass:
// a fill count marks which slots have been written, and the rest read as zero.
// When the output word is not taken the whole pipeline holds and s_tready
// falls in the same cycle.
//
module interpolating_variable_delay_line_top
(
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] sample_in, [47:24] delay_samples
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [23:0] sample_out
);
    import ivdl_pkg::*;

    logic [CFG_W-1:0]           buffer_length_reg;
    logic [LEN_W-1:0]           len;
    logic                       adv;
    logic                       cfg_write;
    logic signed [SAMPLE_W-1:0] sample_out;
    ivdl_req_t                  req;
    ivdl_rd_t                   rd;

    // Writes complete in the access phase; the port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= LEN_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_BUFFER_LENGTH))
        begin
            buffer_length_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BUFFER_LENGTH) ? 32'(buffer_length_reg) : '0;

    // The length in use is the register saturated to LEN_MIN and the store depth.
    always_comb
    begin
        if (buffer_length_reg < CFG_W'(LEN_MIN))
        begin
            len = LEN_W'(LEN_MIN);
        end
        else if (32'(buffer_length_reg) > 32'(MAX_DEPTH))
        begin
            len = LEN_W'(MAX_DEPTH);
        end
        else
        begin
            len = LEN_W'(buffer_length_reg);
        end
    end

    // Every stage moves together unless a finished word is left waiting.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    ivdl_addr_gen u_addr_gen
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (s_tvalid),
        .sample_in     (s_tdata[SAMPLE_W-1:0]),
        .delay_samples (s_tdata[SAMPLE_W +: DELAY_W]),
        .len           (len),
        .req           (req)
    );

    ivdl_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .req   (req),
        .rd    (rd)
    );

    ivdl_interp u_interp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .rd        (rd),
        .out_valid (m_tvalid),
        .out_data  (sample_out)
    );

    assign m_tdata = sample_out;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the interpolating variable delay line. Words are
// streamed in with random gaps and the output is drained with random stalls.
// Every output word is compared with a behavioural copy of the delay line
// that is kept inside the bench.
// ----------------------------------------------------------------------------
module tb;

    import ivdl_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    // The pipeline is four stages deep; quiet after the last output word
    // leaves the block with nothing in flight.
    localparam int SETTLE_CYCLES  = 8;
    // Stalls and configuration pauses are far shorter than this limit, so a
    // quiet spell that reaches it can only mean a hang.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PRINT_LIMIT    = 100;
    localparam int RANDOM_WORDS   = 800;
    localparam int LENGTH_PHASES  = 9;

    // A register index with nothing behind it; writes to it must be ignored.
    localparam int unsigned REG_SPARE = 1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [23:0] sample_in, [47:24] delay_samples
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [23:0] sample_out

    interpolating_variable_delay_line_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // The bench's own copy of the delay line: the sample ring, its write
    // pointer and the length register as last written.
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] line_store [MAX_DEPTH];
    int unsigned                line_wr_pos;
    logic [CFG_W-1:0]           line_len_reg;

    // Output words still owed by the block, oldest first.
    logic signed [SAMPLE_W-1:0] pending_outputs [$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    // While set, neither side idles, so the block runs at its full rate.
    bit full_rate      = 1'b0;

    // The length in use: the register saturated into the range the ring has.
    function automatic int unsigned active_length();
        int unsigned len;
        len = 32'(line_len_reg);
        if (len < LEN_MIN)
        begin
            len = LEN_MIN;
        end
        if (len > MAX_DEPTH)
        begin
            len = MAX_DEPTH;
        end
        return len;
    endfunction

    // Reads the two taps around the requested delay, blends them by the
    // fractional part, then writes the new sample and advances the pointer.
    function automatic logic signed [SAMPLE_W-1:0] interpolate_and_store(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [DELAY_W-1:0]         dly);
        int unsigned                len;
        int unsigned                tap;
        int unsigned                frac;
        int unsigned                wp;
        int unsigned                rd_near;
        int unsigned                rd_far;
        longint unsigned            dl;
        longint unsigned            ceiling;
        longint                     prod;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
        len     = active_length();
        dl      = 64'(dly);
        ceiling = 64'(len);
        ceiling = ceiling << FRAC_W;
        // Too long a delay pins to the last slot with no fraction; anything
        // under one sample is raised to exactly one sample.
        if (dl >= ceiling)
        begin
            dl = longint'(len - 1) << FRAC_W;
        end
        else if (dl < (64'd1 << FRAC_W))
        begin
            dl = 64'd1 << FRAC_W;
        end
        tap  = 32'(dl >> FRAC_W);
        frac = 32'(dl & ((64'd1 << FRAC_W) - 1));
        // A pointer left beyond a freshly shortened ring restarts at slot zero.
        wp      = (line_wr_pos >= len) ? 0 : line_wr_pos;
        rd_near = (wp >= tap) ? wp - tap : wp + len - tap;
        rd_far  = (rd_near >= 1) ? rd_near - 1 : rd_near + len - 1;
        y1      = line_store[rd_near];
        y2      = line_store[rd_far];
        // The arithmetic shift of the exact product rounds towards minus infinity.
        prod    = longint'(frac) * (longint'(y2) - longint'(y1));
        line_store[wp] = smp;
        line_wr_pos    = (wp + 1 >= len) ? 0 : wp + 1;
        return SAMPLE_W'(longint'(y1) + (prod >>> FRAC_W));
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (full_rate || roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        if ($urandom_range(0, 99) < 12)
        begin
            case ($urandom_range(0, 3))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return SAMPLE_W'($urandom());
    endfunction

    // Most delays lie between zero and just past the ring length, so both clamps and
    // the whole span of taps are reached; the rest cover every bit of the field.
    function automatic logic [DELAY_W-1:0] random_delay();
        int unsigned span;
        span = (active_length() + 2) << FRAC_W;
        if ($urandom_range(0, 99) < 70)
        begin
            return DELAY_W'($urandom_range(0, span));
        end
        return DELAY_W'($urandom());
    endfunction

    // Printing stops after a while so that a broken block cannot flood the
    // log, but every mismatch still counts.
    task automatic report_mismatch(input string what, input string detail);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch on %s: %s", $realtime, what, detail);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side: one word per call, after a random gap. tvalid stays high
    // between back-to-back words and is only lowered when a gap is taken.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic signed [SAMPLE_W-1:0] smp,
                             input logic [DELAY_W-1:0]         dly);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dly, smp};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pending_outputs.push_back(interpolate_and_store(smp, dly));
    endtask

    // Stops the input stream and waits until the block has nothing in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One configuration transfer: a setup cycle, then an access cycle that
    // completes at the first edge with pready high, then a return to idle so
    // that back-to-back transfers each start on a fresh edge.
    task automatic apb_access(input int unsigned idx, input logic is_write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= 3'(idx * 4);
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_length_register();
        logic [31:0] readback;
        apb_access(int'(REG_BUFFER_LENGTH), 1'b0, '0, readback);
        if (readback !== 32'(line_len_reg))
        begin
            report_mismatch("buffer_length readback",
                            $sformatf("expected %0d, got %0d", line_len_reg, readback));
        end
    endtask

    // Registers are only written with the block idle; the length is read back
    // after every write, which also shows that writes to spare indexes are
    // ignored.
    task automatic write_register(input int unsigned idx, input logic [31:0] value);
        logic [31:0] unused;
        settle();
        apb_access(idx, 1'b1, value, unused);
        if (idx == int'(REG_BUFFER_LENGTH))
        begin
            line_len_reg = value[CFG_W-1:0];
        end
        check_length_register();
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, and the comparison of each word
    // taken with the oldest one owed.
    // ------------------------------------------------------------------------
    initial
    begin : sink_pacing
        int stall;
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : output_check
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outputs.size() == 0)
            begin
                report_mismatch("sample_out",
                                $sformatf("word %0d with none owed", $signed(m_tdata)));
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (m_tdata !== want)
                begin
                    report_mismatch("sample_out",
                                    $sformatf("expected %0d, got %0d",
                                              want, $signed(m_tdata)));
                end
            end
        end
    end

    // The watchdog counts cycles in which neither stream moves a word.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Straight out of reset: the length reads back as its reset value and the
    // cleared ring gives zeros, with both delay clamps applied to it.
    task automatic test_reset_defaults();
        check_length_register();
        send_word(SAMPLE_MAX, '0);
        send_word(SAMPLE_MIN, '1);
        send_word('0, {16'd1, 8'hFF});
        send_word('1, {16'd1, 8'h00});
    endtask

    // A four-slot ring filled with alternating extremes, so that the largest
    // differences meet the largest fractions, under every delay clamp.
    task automatic test_delay_clamps();
        write_register(int'(REG_BUFFER_LENGTH), 32'd4);
        send_word(SAMPLE_MAX, 24'h000000);
        send_word(SAMPLE_MIN, 24'h000080);
        send_word(SAMPLE_MAX, 24'h000100);
        send_word(SAMPLE_MIN, 24'h0003FF);
        send_word(SAMPLE_MAX, 24'h000400);
        send_word(SAMPLE_MIN, 24'h0001FF);
        send_word('0, 24'h000180);
        send_word('1, 24'hFFFFFF);
    endtask

    // Lengths below the smallest ring and above the largest are saturated.
    task automatic test_length_extremes();
        write_register(int'(REG_BUFFER_LENGTH), 32'd0);
        send_word(random_sample(), 24'h0001C0);
        write_register(int'(REG_BUFFER_LENGTH), 32'd1);
        send_word(random_sample(), 24'hFFFFFF);
        write_register(int'(REG_BUFFER_LENGTH), 32'((1 << CFG_W) - 1));
        send_word(random_sample(), 24'hFFFFFF);
        send_word(random_sample(), {16'(MAX_DEPTH - 1), 8'hFF});
        write_register(int'(REG_BUFFER_LENGTH), 32'(MAX_DEPTH));
        send_word(random_sample(), 24'hFFFFFF);
    endtask

    // Advance the pointer in a longer ring, then shrink the ring below it.
    task automatic test_pointer_beyond_length();
        write_register(int'(REG_BUFFER_LENGTH), 32'd8);
        repeat (6) send_word(random_sample(), random_delay());
        write_register(int'(REG_BUFFER_LENGTH), 32'd2);
        send_word(random_sample(), 24'h000180);
        send_word(random_sample(), 24'h000100);
    endtask

    // A write to an index with no register must leave the length alone.
    task automatic test_spare_register();
        write_register(REG_SPARE, 32'd5);
        send_word(random_sample(), 24'h000280);
        send_word(random_sample(), random_delay());
    endtask

    // Random words over a range of ring lengths, the extremes among them and
    // one random register value; two phases run with no idling at all.
    task automatic test_random_traffic();
        int unsigned lengths [LENGTH_PHASES];
        lengths = '{2, 3, 17, 64, 300, 4800, MAX_DEPTH, (1 << CFG_W) - 1, 0};
        lengths[LENGTH_PHASES-1] = $urandom_range(0, (1 << CFG_W) - 1);
        for (int p = 0; p < LENGTH_PHASES; p++)
        begin
            write_register(int'(REG_BUFFER_LENGTH), 32'(lengths[p]));
            full_rate = (p == 2 || p == 6);
            repeat (RANDOM_WORDS / LENGTH_PHASES)
            begin
                send_word(random_sample(), random_delay());
            end
            full_rate = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, the directed tests, the random traffic, then a
    // drain before the verdict.
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (line_store[i])
        begin
            line_store[i] = '0;
        end
        line_wr_pos  = 0;
        line_len_reg = LEN_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_delay_clamps();
        test_length_extremes();
        test_pointer_beyond_length();
        test_spare_register();
        test_random_traffic();
        settle();
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
